>>> rtl/core/i3u_pkg.sv
// Shared types, codes and UTF-8 helpers for the ID3 text transcoder.
package i3u_pkg;

    // Frame encoding codes carried in the first frame byte
    localparam logic [1:0] ENC_LATIN1  = 2'd0;
    localparam logic [1:0] ENC_UTF16   = 2'd1;
    localparam logic [1:0] ENC_UTF16BE = 2'd2;
    localparam logic [1:0] ENC_UTF8    = 2'd3;

    // Frame status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_UNKNOWN   = 2'd1;
    localparam logic [1:0] ST_SHORT     = 2'd2;
    localparam logic [1:0] ST_ODD_LEN   = 2'd3;

    // Default depth of the command queue between front and back
    localparam int CMD_QUEUE_DEPTH = 4;

    localparam logic [20:0] CP_REPLACEMENT = 21'h00FFFD;
    localparam logic [20:0] CP_SUPP_BASE   = 21'h010000;

    // One decoded input byte: up to two code points and the end-of-frame status
    typedef struct packed {
        logic [20:0] cp0;
        logic [2:0]  len0;
        logic [20:0] cp1;
        logic [2:0]  len1;
        logic        frame_end;
        logic [1:0]  status;
    } cmd_t;

    // Number of UTF-8 bytes for a code point
    function automatic logic [2:0] utf8_len(input logic [20:0] cp);
        logic [2:0] len;
        if (cp <= 21'h00007F)
            len = 3'd1;
        else if (cp <= 21'h0007FF)
            len = 3'd2;
        else if (cp <= 21'h00FFFF)
            len = 3'd3;
        else
            len = 3'd4;
        return len;
    endfunction

    // Byte k of the UTF-8 form; length one passes the low byte as it is
    function automatic logic [7:0] utf8_byte(input logic [20:0] cp,
                                             input logic [2:0] len,
                                             input logic [1:0] k);
        logic [7:0] b;
        b = {2'b10, cp[5:0]};
        case (len)
            3'd1: b = cp[7:0];
            3'd2:
            begin
                if (k == 2'd0)
                    b = {3'b110, cp[10:6]};
            end
            3'd3:
            begin
                if (k == 2'd0)
                    b = {4'b1110, cp[15:12]};
                else if (k == 2'd1)
                    b = {2'b10, cp[11:6]};
            end
            default:
            begin
                if (k == 2'd0)
                    b = {5'b11110, cp[20:18]};
                else if (k == 2'd1)
                    b = {2'b10, cp[17:12]};
                else if (k == 2'd2)
                    b = {2'b10, cp[11:6]};
            end
        endcase
        return b;
    endfunction

endpackage

>>> rtl/core/i3u_front.sv
// Front part: accept frame bytes, track decoder state, issue byte commands.
module i3u_front
    import i3u_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic [7:0] frame_byte,
    input  logic       frame_start,
    input  logic       frame_end,
    output logic       cmd_write,
    output cmd_t       cmd
);

    logic [1:0] enc_reg, enc_next;
    logic       unk_reg, unk_next;
    logic [1:0] count_reg, count_next;
    logic [7:0] held_reg, held_next;
    logic       hv_reg, hv_next;
    logic       be_reg, be_next;
    logic [9:0] hu_reg, hu_next;
    logic       hp_reg, hp_next;
    logic       ended_reg, ended_next;

    // Work out next state and the command for this word
    always_comb
    begin
        logic [15:0] unit;
        logic        skip;
        logic        is_high;
        logic        is_low;
        logic [20:0] byte_cp;

        enc_next   = enc_reg;
        unk_next   = unk_reg;
        count_next = count_reg;
        held_next  = held_reg;
        hv_next    = hv_reg;
        be_next    = be_reg;
        hu_next    = hu_reg;
        hp_next    = hp_reg;
        ended_next = ended_reg;
        cmd        = '0;
        skip       = 1'b0;
        unit       = '0;
        is_high    = 1'b0;
        is_low     = 1'b0;
        byte_cp    = {13'd0, frame_byte};

        if (frame_start)
        begin
            enc_next   = (frame_byte <= 8'd3) ? frame_byte[1:0] : ENC_LATIN1;
            unk_next   = (frame_byte > 8'd3);
            count_next = '0;
            held_next  = '0;
            hv_next    = 1'b0;
            be_next    = 1'b1;
            hu_next    = '0;
            hp_next    = 1'b0;
            ended_next = 1'b0;
        end
        else
        begin
            if (count_reg != 2'd3)
                count_next = count_reg + 2'd1;
            if (!unk_reg)
            begin
                if (enc_reg == ENC_LATIN1 || enc_reg == ENC_UTF8)
                begin
                    // Single byte text: NUL ends output for the frame
                    if (!ended_reg)
                    begin
                        if (frame_byte == 8'd0)
                            ended_next = 1'b1;
                        else
                        begin
                            cmd.cp0  = byte_cp;
                            cmd.len0 = (enc_reg == ENC_UTF8) ? 3'd1 : utf8_len(byte_cp);
                        end
                    end
                end
                else if (!hv_reg)
                begin
                    held_next = frame_byte;
                    hv_next   = 1'b1;
                end
                else
                begin
                    hv_next = 1'b0;
                    // Byte order mark on the first unit of a UTF-16 frame
                    if (enc_reg == ENC_UTF16 && count_reg == 2'd1)
                    begin
                        if (held_reg == 8'hFE && frame_byte == 8'hFF)
                        begin
                            be_next = 1'b1;
                            skip    = 1'b1;
                        end
                        else if (held_reg == 8'hFF && frame_byte == 8'hFE)
                        begin
                            be_next = 1'b0;
                            skip    = 1'b1;
                        end
                        else
                            be_next = 1'b1;
                    end
                    unit    = be_next ? {held_reg, frame_byte} : {frame_byte, held_reg};
                    is_high = (unit >= 16'hD800) && (unit <= 16'hDBFF);
                    is_low  = (unit >= 16'hDC00) && (unit <= 16'hDFFF);
                    if (!skip)
                    begin
                        if (hp_reg && is_low)
                        begin
                            // Join the surrogate pair
                            hp_next = 1'b0;
                            if (!ended_reg)
                            begin
                                cmd.cp0  = CP_SUPP_BASE + {1'b0, hu_reg, unit[9:0]};
                                cmd.len0 = 3'd4;
                            end
                        end
                        else
                        begin
                            // Unpaired high unit becomes a replacement
                            if (hp_reg && !ended_reg)
                            begin
                                cmd.cp0  = CP_REPLACEMENT;
                                cmd.len0 = 3'd3;
                            end
                            hp_next = 1'b0;
                            if (is_high)
                            begin
                                hu_next = unit[9:0];
                                hp_next = 1'b1;
                            end
                            else if (!ended_reg)
                            begin
                                if (is_low)
                                begin
                                    cmd.cp1  = CP_REPLACEMENT;
                                    cmd.len1 = 3'd3;
                                end
                                else if (unit == 16'd0)
                                    ended_next = 1'b1;
                                else
                                begin
                                    cmd.cp1  = {5'd0, unit};
                                    cmd.len1 = utf8_len({5'd0, unit});
                                end
                            end
                        end
                    end
                end
            end
        end

        // Frame status on the final byte
        cmd.frame_end = frame_end;
        if (frame_end)
        begin
            if (unk_next)
                cmd.status = ST_UNKNOWN;
            else if (enc_next == ENC_UTF16 && count_next < 2'd2)
                cmd.status = ST_SHORT;
            else if ((enc_next == ENC_UTF16 || enc_next == ENC_UTF16BE) && hv_next)
                cmd.status = ST_ODD_LEN;
            else
                cmd.status = ST_OK;
        end
    end

    assign cmd_write = accept && (cmd.len0 != 3'd0 || cmd.len1 != 3'd0 || frame_end);

    // Advance decoder state on each accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enc_reg   <= ENC_LATIN1;
            unk_reg   <= 1'b0;
            count_reg <= '0;
            held_reg  <= '0;
            hv_reg    <= 1'b0;
            be_reg    <= 1'b1;
            hu_reg    <= '0;
            hp_reg    <= 1'b0;
            ended_reg <= 1'b0;
        end
        else if (accept)
        begin
            enc_reg   <= enc_next;
            unk_reg   <= unk_next;
            count_reg <= count_next;
            held_reg  <= held_next;
            hv_reg    <= hv_next;
            be_reg    <= be_next;
            hu_reg    <= hu_next;
            hp_reg    <= hp_next;
            ended_reg <= ended_next;
        end
    end

endmodule

>>> rtl/core/i3u_queue.sv
// Short command queue between the front and back parts.
module i3u_queue
    import i3u_pkg::*;
#(
    parameter int DEPTH = CMD_QUEUE_DEPTH
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  cmd_t wr_data,
    input  logic rd_en,
    output cmd_t rd_data,
    output logic q_empty,
    output logic q_full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    cmd_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign q_empty = (cnt_reg == '0);
    assign q_full  = (cnt_reg == CNT_W'(DEPTH));
    assign rd_data = slot_reg[rd_ptr_reg];

    // Wrap pointers and track fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (wr_en)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (rd_en)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (wr_en && !rd_en)
            cnt_next = cnt_reg + CNT_W'(1);
        else if (rd_en && !wr_en)
            cnt_next = cnt_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store the incoming command
    always_ff @(posedge clk)
    begin
        if (wr_en)
            slot_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

>>> rtl/core/i3u_back.sv
// Back part: expand queued commands into UTF-8 result words.
module i3u_back
    import i3u_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cmd_t       cmd,
    input  logic       cmd_avail,
    output logic       cmd_take,
    input  logic       pop,
    output logic       empty,
    output logic [7:0] text_byte,
    output logic       byte_present,
    output logic       run_last,
    output logic       frame_done,
    output logic [1:0] frame_status
);

    logic [2:0] k_reg, k_next;
    logic       ov_reg;
    logic [7:0] byte_reg;
    logic       present_reg;
    logic       last_reg;
    logic       done_reg;
    logic [1:0] status_reg;

    logic       load;
    logic [2:0] total;
    logic [2:0] k1;
    logic       is_last;
    logic       none;
    logic [7:0] sel_byte;

    assign total   = cmd.len0 + cmd.len1;
    assign none    = (total == 3'd0);
    assign k1      = k_reg - cmd.len0;
    assign is_last = none || ((k_reg + 3'd1) == total);
    assign load    = cmd_avail && (!ov_reg || pop);
    assign cmd_take = load && is_last;

    // Pick the byte from the first or second code point
    always_comb
    begin
        if (k_reg < cmd.len0)
            sel_byte = utf8_byte(cmd.cp0, cmd.len0, k_reg[1:0]);
        else
            sel_byte = utf8_byte(cmd.cp1, cmd.len1, k1[1:0]);
        k_next = k_reg;
        if (load)
            k_next = is_last ? 3'd0 : k_reg + 3'd1;
    end

    // Hold the output word until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg  <= '0;
            ov_reg <= 1'b0;
        end
        else
        begin
            k_reg <= k_next;
            if (load)
                ov_reg <= 1'b1;
            else if (pop)
                ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg    <= none ? 8'd0 : sel_byte;
            present_reg <= !none;
            last_reg    <= is_last;
            done_reg    <= is_last && cmd.frame_end;
            status_reg  <= (is_last && cmd.frame_end) ? cmd.status : ST_OK;
        end
    end

    assign empty        = !ov_reg;
    assign text_byte    = byte_reg;
    assign byte_present = present_reg;
    assign run_last     = last_reg;
    assign frame_done   = done_reg;
    assign frame_status = status_reg;

endmodule

>>> rtl/core/id3_text_to_utf8_transcoder_unit.sv
// Top level of the ID3 text frame to UTF-8 transcoder.
//
// Input channel: frame bytes, one per word, written with push while full is
// low. frame_start marks the encoding byte, frame_end the last byte.
// Output channel: UTF-8 result words, read with pop while empty is low. Each
// word carries text_byte and byte_present; run_last closes the words caused
// by one input byte, and frame_done with frame_status closes a frame.
// A byte with no result and no frame_end produces nothing on the output side.
// The first result of an input byte reaches the result ports through the
// command queue and the output register. Throughput: the back part emits one
// result word per cycle while the receiver pops and the queue holds commands;
// an input byte causes up to six result words. The front takes one byte per
// cycle while the command queue (QUEUE_DEPTH entries) has room.
// When the receiver stalls, the output register holds its word, the queue
// fills and full rises; nothing is lost.
// Reset clears the decoder state to Latin-1 and empties queue and output.
module id3_text_to_utf8_transcoder_unit
    import i3u_pkg::*;
#(
    parameter int QUEUE_DEPTH = CMD_QUEUE_DEPTH
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] frame_byte,
    input  logic       frame_start,
    input  logic       frame_end,
    input  logic       pop,
    output logic       empty,
    output logic [7:0] text_byte,
    output logic       byte_present,
    output logic       run_last,
    output logic       frame_done,
    output logic [1:0] frame_status
);

    logic accept;
    logic cmd_write;
    cmd_t front_cmd;
    cmd_t head_cmd;
    logic q_empty;
    logic q_full;
    logic cmd_take;

    assign full   = q_full;
    assign accept = push && !q_full;

    // Classify input bytes
    i3u_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .frame_byte (frame_byte),
        .frame_start(frame_start),
        .frame_end  (frame_end),
        .cmd_write  (cmd_write),
        .cmd        (front_cmd)
    );

    // Decouple front and back
    i3u_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (cmd_write),
        .wr_data(front_cmd),
        .rd_en  (cmd_take),
        .rd_data(head_cmd),
        .q_empty(q_empty),
        .q_full (q_full)
    );

    // Emit UTF-8 words
    i3u_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (head_cmd),
        .cmd_avail   (!q_empty),
        .cmd_take    (cmd_take),
        .pop         (pop),
        .empty       (empty),
        .text_byte   (text_byte),
        .byte_present(byte_present),
        .run_last    (run_last),
        .frame_done  (frame_done),
        .frame_status(frame_status)
    );

endmodule
